// File: hw/rtl/fctc_pkg.sv
// ----------------------------------------------------------------------------
// fctc_pkg - shared definitions for the fractional clock tick converter
// Field widths, register indexes and reset values of the rate registers.
// ----------------------------------------------------------------------------
`default_nettype none

package fctc_pkg;

  // Field and datapath widths
  localparam int unsigned TicksW  = 16;
  localparam int unsigned RegW    = 24;
  localparam int unsigned ProdW   = 2 * RegW;
  localparam int unsigned OutW    = 64;
  localparam int unsigned CfgIdxW = 3;

  // Iteration counts of the shared adder
  localparam int unsigned MulSteps = TicksW;
  localparam int unsigned DivSteps = OutW;
  localparam int unsigned CntW     = $clog2(DivSteps);

  // Rate register indexes
  localparam logic [CfgIdxW-1:0] RegInClockNum  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegInClockDen  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOutClockNum = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOutClockDen = 3'd3;

  // Reset value of every rate register
  localparam logic [RegW-1:0] RegReset = 24'd1;

endpackage : fctc_pkg

`default_nettype wire

// File: hw/rtl/fractional_clock_tick_converter.sv
// ----------------------------------------------------------------------------
// fractional_clock_tick_converter - input clock ticks to output clock ticks
// Forms N = in_den*out_num and D = in_num*out_den, then returns
// floor((N*ticks + rem)/D) and keeps the leftover as the new remainder.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                     | payload
//  ----------+-----------+-------------------------------+---------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready | in_ticks  (16 bits)
//  m_axis    | out       | m_axis_tvalid / m_axis_tready | out_ticks (64 bits)
//  cfg       | in        | cfg_we_i                      | index 3b, data 24b
//
//  From acceptance, a transaction forms the two 24x24 rate products in a shared
//  multiplier, then runs 16 shift-add steps and 64 restoring division steps
//  through one shared 65-bit adder, then an output state. A zero divisor skips
//  the steps and returns zero. Reset sets the rates to 1 and clears the
//  remainder; a rate write also clears the remainder. A result waits in the
//  output register; the next transaction is taken meanwhile and holds in its
//  last step until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module fractional_clock_tick_converter (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Input stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [fctc_pkg::TicksW-1:0]         s_axis_tdata,   // [15:0] in_ticks
  // Output stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [fctc_pkg::OutW-1:0]                m_axis_tdata,   // [63:0] out_ticks
  // Configuration write port
  input  wire logic                                cfg_we_i,
  input  wire logic [fctc_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [fctc_pkg::RegW-1:0]           cfg_data_i
);

  localparam int unsigned OutW   = fctc_pkg::OutW;
  localparam int unsigned ProdW  = fctc_pkg::ProdW;
  localparam int unsigned RegW   = fctc_pkg::RegW;
  localparam int unsigned TicksW = fctc_pkg::TicksW;
  localparam int unsigned CntW   = fctc_pkg::CntW;

  localparam logic [CntW-1:0] MulLast = CntW'(fctc_pkg::MulSteps - 1);
  localparam logic [CntW-1:0] DivLast = CntW'(fctc_pkg::DivSteps - 1);

  // Sequencer states
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMulN = 3'd1;
  localparam logic [2:0] StMulD = 3'd2;
  localparam logic [2:0] StMult = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  logic [RegW-1:0]   in_num_q, in_den_q, out_num_q, out_den_q;
  logic [ProdW-1:0]  rem_q;

  logic [ProdW-1:0]  n_q, d_q;
  logic [OutW-1:0]   acc_q;
  logic [OutW-1:0]   mcand_q;
  logic [TicksW-1:0] tk_q;
  logic [ProdW-1:0]  pr_q;

  logic [OutW-1:0]   res_q;
  logic              out_valid_q, out_valid_d;

  logic [RegW-1:0]   mul_a, mul_b;
  logic [ProdW-1:0]  mul_p;

  logic [OutW-1:0]   add_a, add_b;
  logic              add_cin;
  logic [OutW:0]     add_sum;

  logic [ProdW:0]    div_shift;
  logic              div_ge;
  logic [ProdW-1:0]  div_rem;
  logic              out_free;

  // Shared rate multiplier: N in one state, D in the next
  always_comb begin
    if (state_q == StMulN) begin
      mul_a = in_den_q;
      mul_b = out_num_q;
    end else begin
      mul_a = in_num_q;
      mul_b = out_den_q;
    end
  end
  assign mul_p = mul_a * mul_b;

  // Shared adder: add the multiplicand or subtract the divisor
  assign div_shift = {pr_q, acc_q[OutW-1]};

  always_comb begin
    if (state_q == StDiv) begin
      add_a   = OutW'(div_shift);
      add_b   = ~OutW'(d_q);
      add_cin = 1'b1;
    end else begin
      add_a   = acc_q;
      add_b   = mcand_q;
      add_cin = 1'b0;
    end
  end
  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{OutW{1'b0}}, add_cin};

  // Carry out means the shifted partial remainder reached the divisor
  assign div_ge  = add_sum[OutW];
  assign div_rem = div_ge ? add_sum[ProdW-1:0] : div_shift[ProdW-1:0];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == StIdle);

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) state_d = StMulN;
      end
      StMulN: state_d = StMulD;
      StMulD: begin
        cnt_d = '0;
        if (in_num_q == '0 || out_den_q == '0) state_d = StOut;
        else                                   state_d = StMult;
      end
      StMult: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == MulLast) begin
          cnt_d   = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivLast) state_d = StOut;
      end
      StOut: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Rate registers and remainder; a rate write drops the remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_num_q  <= fctc_pkg::RegReset;
      in_den_q  <= fctc_pkg::RegReset;
      out_num_q <= fctc_pkg::RegReset;
      out_den_q <= fctc_pkg::RegReset;
      rem_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          fctc_pkg::RegInClockNum: begin
            in_num_q <= cfg_data_i;
            rem_q    <= '0;
          end
          fctc_pkg::RegInClockDen: begin
            in_den_q <= cfg_data_i;
            rem_q    <= '0;
          end
          fctc_pkg::RegOutClockNum: begin
            out_num_q <= cfg_data_i;
            rem_q     <= '0;
          end
          fctc_pkg::RegOutClockDen: begin
            out_den_q <= cfg_data_i;
            rem_q     <= '0;
          end
          default: ;
        endcase
      end
      if (state_q == StDiv && cnt_q == DivLast) rem_q <= div_rem;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) tk_q <= s_axis_tdata;
      end
      StMulN: n_q <= mul_p;
      StMulD: begin
        d_q     <= mul_p;
        mcand_q <= OutW'(n_q);
        if (in_num_q == '0 || out_den_q == '0) acc_q <= '0;
        else                                   acc_q <= OutW'(rem_q);
      end
      StMult: begin
        if (tk_q[0]) acc_q <= add_sum[OutW-1:0];
        mcand_q <= {mcand_q[OutW-2:0], 1'b0};
        tk_q    <= {1'b0, tk_q[TicksW-1:1]};
        pr_q    <= '0;
      end
      StDiv: begin
        pr_q  <= div_rem;
        acc_q <= {acc_q[OutW-2:0], div_ge};
      end
      StOut: begin
        if (out_free) res_q <= acc_q;
      end
      default: ;
    endcase
  end

  // Hold the result until the output transaction completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;
    if (state_q == StOut && out_free) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;

endmodule : fractional_clock_tick_converter

`default_nettype wire
